// File: src/hnep_pkg.sv
`default_nettype none

package hnep_pkg;

    localparam int unsigned TYPE_W      = 6;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned IN_DATA_W   = 16;
    localparam int unsigned OUT_DATA_W  = 8;

    localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'h03;
    localparam logic [BYTE_W-1:0] ZERO_BYTE   = 8'h00;
    localparam logic [BYTE_W-1:0] ONE_BYTE    = 8'h01;
    localparam logic [BYTE_W-1:0] TID_TSA_N   = 8'h02;

    localparam logic [TYPE_W-1:0] TYPE_TSA_N       = 6'd2;
    localparam logic [TYPE_W-1:0] TYPE_UNSPECIFIED = 6'd62;

    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_PAYLOAD = 1'b1;

    localparam logic [IDX_W-1:0] START_LEN   = 3'd6;
    localparam logic [IDX_W-1:0] IDX_SC_LAST = 3'd3;
    localparam logic [IDX_W-1:0] IDX_HDR0    = 3'd4;

    localparam logic [1:0] ZRUN_MAX = 2'd2;

    typedef struct packed {
        logic              func;
        logic [TYPE_W-1:0] nal_type;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } item_t;

    function automatic logic [BYTE_W-1:0] start_byte(
        input logic [IDX_W-1:0]  idx,
        input logic [TYPE_W-1:0] nal_type
    );
        logic [BYTE_W-1:0] b;
        begin
            if (idx < IDX_SC_LAST)
            begin
                b = ZERO_BYTE;
            end
            else if (idx == IDX_SC_LAST)
            begin
                b = ONE_BYTE;
            end
            else if (idx == IDX_HDR0)
            begin
                b = {1'b0, nal_type, 1'b0};
            end
            else
            begin
                b = (nal_type == TYPE_TSA_N) ? TID_TSA_N : ONE_BYTE;
            end
            return b;
        end
    endfunction

endpackage

`default_nettype wire

// File: src/hevc_nal_emulation_prevention_top.sv
`default_nettype none

// channel   dir  tdata (low bit up)               tuser          tlast
// s_axis    in   nal_type[5:0], data_byte[13:6]   func           last
// m_axis    out  out_byte[7:0]                    run_end        nal_end
//
// One output byte per cycle. A payload item gives 1 to 3 bytes (escape,
// byte, trailing escape); a start item gives 6 bytes (start code, header).
// The item register, zero run and escape enable set that count; the next item is
// taken in the cycle its predecessor's final byte enters the output register.
// rst_n clears the valid flags and zero run and sets escape enable, asynchronously.
// A stall on m_axis holds the output register and the item in progress.

module hevc_nal_emulation_prevention_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // nal_type[5:0], data_byte[13:6], zero[15:14]
    input  wire logic [hnep_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  wire logic                                s_axis_tuser,  // func
    input  wire logic                                s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [hnep_pkg::OUT_DATA_W-1:0]          m_axis_tdata,  // out_byte[7:0]
    output logic                                     m_axis_tuser,  // run_end
    output logic                                     m_axis_tlast   // nal_end
);

    hnep_pkg::item_t                  item_reg;
    logic                             item_valid_reg;
    logic [hnep_pkg::IDX_W-1:0]       idx_reg;
    logic [hnep_pkg::IDX_W-1:0]       idx_next;
    logic [1:0]                       zrun_reg;
    logic [1:0]                       zrun_next;
    logic                             esc_en_reg;
    logic                             esc_en_next;

    logic [hnep_pkg::BYTE_W-1:0]      byte_reg;
    logic                             out_valid_reg;
    logic                             run_end_reg;
    logic                             nal_end_reg;

    logic                             has_esc;
    logic                             has_trail;
    logic [hnep_pkg::IDX_W-1:0]       len;
    logic [hnep_pkg::IDX_W-1:0]       pidx;
    logic                             final_byte;
    logic                             out_load;
    logic                             in_take;
    logic [hnep_pkg::BYTE_W-1:0]      byte_next;
    logic [1:0]                       zrun_base;

    always_comb
    begin
        has_esc   = esc_en_reg && (zrun_reg >= hnep_pkg::ZRUN_MAX)
                    && (item_reg.data_byte <= hnep_pkg::ESCAPE_BYTE);
        has_trail = item_reg.last && (item_reg.data_byte == hnep_pkg::ZERO_BYTE);
        if (item_reg.func == hnep_pkg::FUNC_START)
        begin
            len = hnep_pkg::START_LEN;
        end
        else
        begin
            len = 3'd1 + {2'b00, has_esc} + {2'b00, has_trail};
        end
        final_byte = (idx_reg == (len - 3'd1));
        out_load   = item_valid_reg && (!out_valid_reg || m_axis_tready);
        in_take    = s_axis_tvalid && s_axis_tready;
        s_axis_tready = !item_valid_reg || (out_load && final_byte);

        // payload position with the escape slot removed
        pidx = idx_reg - {2'b00, has_esc};
        if (item_reg.func == hnep_pkg::FUNC_START)
        begin
            byte_next = hnep_pkg::start_byte(idx_reg, item_reg.nal_type);
        end
        else if (has_esc && (idx_reg == 3'd0))
        begin
            byte_next = hnep_pkg::ESCAPE_BYTE;
        end
        else if (pidx == 3'd0)
        begin
            byte_next = item_reg.data_byte;
        end
        else
        begin
            byte_next = hnep_pkg::ESCAPE_BYTE;
        end

        idx_next = idx_reg;
        if (in_take)
        begin
            idx_next = '0;
        end
        else if (out_load)
        begin
            idx_next = idx_reg + 3'd1;
        end

        // state after the item completes
        zrun_base   = has_esc ? 2'd0 : zrun_reg;
        zrun_next   = zrun_reg;
        esc_en_next = esc_en_reg;
        if (out_load && final_byte)
        begin
            if (item_reg.func == hnep_pkg::FUNC_START)
            begin
                zrun_next   = 2'd0;
                esc_en_next = (item_reg.nal_type != hnep_pkg::TYPE_UNSPECIFIED);
            end
            else if (has_trail)
            begin
                zrun_next = 2'd0;
            end
            else if (item_reg.data_byte == hnep_pkg::ZERO_BYTE)
            begin
                zrun_next = (zrun_base < hnep_pkg::ZRUN_MAX) ? zrun_base + 2'd1 : zrun_base;
            end
            else
            begin
                zrun_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            zrun_reg       <= 2'd0;
            esc_en_reg     <= 1'b1;
        end
        else
        begin
            idx_reg    <= idx_next;
            zrun_reg   <= zrun_next;
            esc_en_reg <= esc_en_next;
            if (s_axis_tready)
            begin
                item_valid_reg <= s_axis_tvalid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.func      <= s_axis_tuser;
            item_reg.nal_type  <= s_axis_tdata[5:0];
            item_reg.data_byte <= s_axis_tdata[13:6];
            item_reg.last      <= s_axis_tlast;
        end
        if (out_load)
        begin
            byte_reg    <= byte_next;
            run_end_reg <= final_byte;
            nal_end_reg <= final_byte && item_reg.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = byte_reg;
    assign m_axis_tuser  = run_end_reg;
    assign m_axis_tlast  = nal_end_reg;

endmodule

`default_nettype wire
